// ===== rtl/rdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and helpers for the radix digit converter.
package rdc_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int DIGIT_DEPTH_DEF = 32;
   localparam int MAX_RESULTS     = 32;

   localparam int VALUE_FIELD_W = 32;
   localparam int RADIX_W       = 5;
   localparam int DIGIT_W       = 4;
   localparam int CHAR_W        = 7;
   localparam int REQ_DATA_W    = 32;
   localparam int RSP_DATA_W    = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd2;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

   function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] digit);
      logic [CHAR_W-1:0] glyph;
      if (digit < DIGIT_TEN) begin
         glyph = CHAR_ZERO + {3'b000, digit};
      end else begin
         glyph = CHAR_A + {3'b000, digit - DIGIT_TEN};
      end
      return glyph;
   endfunction

endpackage

// ===== rtl/rdc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
module rdc_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rdc_divider.sv =====
`timescale 1ns / 1ps
// Divide by a small base using a registered reciprocal multiply and one combinational correction step.
module rdc_divider #(
   parameter int WORK_W = 32
) (
   input  logic                        clock,
   input  logic                        start,
   input  logic [WORK_W-1:0]           dividend,
   input  logic [rdc_pkg::RADIX_W-1:0] radix,
   output logic [WORK_W-1:0]           quotient,
   output logic [rdc_pkg::DIGIT_W-1:0] remainder
);

   import rdc_pkg::*;

   localparam logic [WORK_W:0] SCALE = {1'b1, {WORK_W{1'b0}}};
   localparam int PW = 2 * WORK_W;
   localparam int EW = WORK_W + RADIX_W;

   logic [WORK_W-1:0]  recip;
   logic [PW-1:0]      prod_ff;
   logic [PW-1:0]      prod_in;
   logic [WORK_W-1:0]  dividend_ff;
   logic [RADIX_W-1:0] radix_ff;
   logic [WORK_W-1:0]  q_est;
   logic [EW-1:0]      q_times_b;
   logic [WORK_W-1:0]  r_est;
   logic [EW-1:0]      r_ext;
   logic [EW-1:0]      b_ext;

   always_comb begin
      case (radix)
         5'd3:    recip = WORK_W'(SCALE / 3);
         5'd4:    recip = WORK_W'(SCALE / 4);
         5'd5:    recip = WORK_W'(SCALE / 5);
         5'd6:    recip = WORK_W'(SCALE / 6);
         5'd7:    recip = WORK_W'(SCALE / 7);
         5'd8:    recip = WORK_W'(SCALE / 8);
         5'd9:    recip = WORK_W'(SCALE / 9);
         5'd10:   recip = WORK_W'(SCALE / 10);
         5'd11:   recip = WORK_W'(SCALE / 11);
         5'd12:   recip = WORK_W'(SCALE / 12);
         5'd13:   recip = WORK_W'(SCALE / 13);
         5'd14:   recip = WORK_W'(SCALE / 14);
         5'd15:   recip = WORK_W'(SCALE / 15);
         5'd16:   recip = WORK_W'(SCALE / 16);
         default: recip = WORK_W'(SCALE / 2);
      endcase
      prod_in = PW'(dividend) * PW'(recip);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff     <= prod_in;
         dividend_ff <= dividend;
         radix_ff    <= radix;
      end
   end

   // The estimate is at most one below the true quotient.
   always_comb begin
      q_est     = prod_ff[PW-1:WORK_W];
      q_times_b = EW'(q_est) * EW'(radix_ff);
      r_est     = dividend_ff - q_times_b[WORK_W-1:0];
      r_ext     = EW'(r_est);
      b_ext     = EW'(radix_ff);
      if (r_ext >= b_ext) begin
         quotient  = q_est + 1'b1;
         remainder = DIGIT_W'(r_ext - b_ext);
      end else begin
         quotient  = q_est;
         remainder = DIGIT_W'(r_ext);
      end
   end

endmodule

// ===== rtl/radix_digit_converter.sv =====
`timescale 1ns / 1ps
// Top level of the radix digit converter: sequencer, base register and digit store.
// Sequence: accept in ST_IDLE, then ST_MUL and ST_DIV per digit from the shared divider,
// ST_READ to fetch the top digit, then one word per cycle while rsp_tready is high.
// Throughput: one value at a time; the divider pass (multiply, then correct)
// sets the conversion time.
// Reset is synchronous and active high; it clears the sequencer and sets the base to 2.
module radix_digit_converter #(
   parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
   parameter int DIGIT_DEPTH = rdc_pkg::DIGIT_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rdc_pkg::REQ_DATA_W-1:0] req_tdata,   // [31:0] value
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rdc_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [6:0] digit_char, [7] zero
   output logic                           rsp_tlast,   // last_digit
   input  logic                           csr_wr_en,
   input  logic [rdc_pkg::RADIX_W-1:0]    csr_wr_data  // radix
);

   import rdc_pkg::*;

   localparam int WORK_W   = (VALUE_WIDTH < VALUE_FIELD_W) ? VALUE_WIDTH : VALUE_FIELD_W;
   localparam int SLOT_LIM = (DIGIT_DEPTH < MAX_RESULTS) ? DIGIT_DEPTH : MAX_RESULTS;
   localparam int ADDR_W   = $clog2(SLOT_LIM);
   localparam int CNT_W    = $clog2(SLOT_LIM + 1);
   localparam logic [CNT_W-1:0] SLOT_LIM_C = CNT_W'(SLOT_LIM);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_READ = 5'b01000,
      ST_SEND = 5'b10000
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [RADIX_W-1:0] radix_ff;
   logic [RADIX_W-1:0] radix_in;
   logic [WORK_W-1:0]  value_ff;
   logic [WORK_W-1:0]  value_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic [ADDR_W-1:0]  idx_ff;
   logic [ADDR_W-1:0]  idx_in;

   logic               div_start;
   logic [WORK_W-1:0]  quotient;
   logic [DIGIT_W-1:0] remainder;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [DIGIT_W-1:0] ram_rd_data;

   always_comb begin
      radix_in = radix_ff;
      if (csr_wr_en && (csr_wr_data inside {[RADIX_MIN:RADIX_MAX]})) begin
         radix_in = csr_wr_data;
      end
   end

   always_comb begin
      state_in    = state_ff;
      value_in    = value_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      div_start   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               value_in = req_tdata[WORK_W-1:0];
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            value_in = quotient;
            if (cnt_ff < SLOT_LIM_C) begin
               ram_wr_en = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
            if (quotient == '0) begin
               idx_in   = ADDR_W'(cnt_in - 1'b1);
               state_in = ST_READ;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) begin
               if (idx_ff == '0) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in      = idx_ff - 1'b1;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_in;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_RESET;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      idx_ff   <= idx_in;
   end

   rdc_divider #(
      .WORK_W (WORK_W)
   ) u_divider (
      .clock     (clock),
      .start     (div_start),
      .dividend  (value_ff),
      .radix     (radix_ff),
      .quotient  (quotient),
      .remainder (remainder)
   );

   rdc_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (SLOT_LIM)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (remainder),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_tdata  = {1'b0, digit_glyph(ram_rd_data)};
   assign rsp_tlast  = (idx_ff == '0);

endmodule

// ===== rtl/rdc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the radix digit converter and the bind that attaches them.
module rdc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [rdc_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rdc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast,
   input logic                           csr_wr_en,
   input logic [rdc_pkg::RADIX_W-1:0]    csr_wr_data
);

   import rdc_pkg::*;

   // A stalled word keeps its character and its last marker.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled word changed");

   // The block never takes a new value while it still delivers digits.
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while output pending");

   // Once a value is taken, the input stays closed in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input reopened right after accept");

   // Every word carries a digit character from 0-9 or A-F.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39) ||
                     (rsp_tdata >= 8'h41 && rsp_tdata <= 8'h46))
      else $error("word is not a digit character");

   // After the last digit is taken, no stray word follows.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("word after last digit");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);
